>>> rtl/uds_pkg.sv
// Shared types and constants for the diagnostic request dispatcher.
// Used by the decode front end, the request queue, the execution back end
// and the top level. No dependencies.
package uds_pkg;

  // Service identifiers.
  localparam logic [7:0] SID_SESSION  = 8'h10;
  localparam logic [7:0] SID_READ_ID  = 8'h22;
  localparam logic [7:0] SID_SECURITY = 8'h27;
  localparam logic [7:0] SID_DOWNLOAD = 8'h34;
  localparam logic [7:0] SID_TRANSFER = 8'h36;
  localparam logic [7:0] SID_EXIT     = 8'h37;
  localparam logic [7:0] SID_TESTER   = 8'h3E;

  // Reply identifiers.
  localparam logic [7:0] RID_NEGATIVE = 8'h7F;
  localparam logic [7:0] RID_SESSION  = 8'h50;
  localparam logic [7:0] RID_DOWNLOAD = 8'h74;
  localparam logic [7:0] RID_TRANSFER = 8'h76;
  localparam logic [7:0] RID_EXIT     = 8'h77;
  localparam logic [7:0] RID_TESTER   = 8'h7E;

  localparam logic [7:0] DOWNLOAD_FORMAT   = 8'h20;
  localparam logic [7:0] TESTER_SUPPRESS   = 8'h80;
  localparam logic [3:0] FORMAT_FOUR_BYTES = 4'h4;

  // Reply frame lengths.
  localparam logic [2:0] LEN_NEGATIVE = 3'd3;
  localparam logic [2:0] LEN_SESSION  = 3'd6;
  localparam logic [2:0] LEN_DOWNLOAD = 3'd4;
  localparam logic [2:0] LEN_TRANSFER = 3'd2;
  localparam logic [2:0] LEN_SHORT    = 3'd1;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  typedef enum logic [2:0] {
    OC_OK         = 3'd0,
    OC_NO_SERVICE = 3'd1,
    OC_NO_SUB     = 3'd2,
    OC_LENGTH     = 3'd3,
    OC_CONDITIONS = 3'd4,
    OC_SECURITY   = 3'd5,
    OC_SEQUENCE   = 3'd6,
    OC_BLOCK      = 3'd7
  } outcome_t;

  typedef enum logic [1:0] {
    SESS_DEFAULT     = 2'd0,
    SESS_PROGRAMMING = 2'd1,
    SESS_EXTENDED    = 2'd2
  } session_t;

  typedef enum logic [1:0] {
    PHASE_IDLE         = 2'd0,
    PHASE_REQUESTED    = 2'd1,
    PHASE_TRANSFERRING = 2'd2
  } phase_t;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_REJECT,
    OP_SESSION,
    OP_DOWNLOAD,
    OP_TRANSFER,
    OP_EXIT,
    OP_TESTER
  } op_t;

  typedef struct packed {
    op_t         op;
    outcome_t    reject_code;  // outcome for OP_REJECT
    logic [7:0]  sid;
    logic [7:0]  prm;          // subfunction already masked for OP_SESSION
    logic        len_ok;       // length check of the gated services
    logic        take_addr;
    logic        take_size;
    logic [31:0] addr;
    logic [31:0] size;
    logic [11:0] xfer_bytes;   // payload bytes of a transfer request
  } q_entry_t;

endpackage

>>> rtl/uds_request_dispatcher.sv
// Diagnostic request dispatcher, top level.
// Ties the decode front end, request queue and execution back end together.
// Depends on uds_pkg, uds_front, uds_queue and uds_back.

// Takes one reassembled diagnostic request per cycle while in_ready is high
// and answers with at most one reply header (outcome, reply id, reply parameter,
// reply length). Requests that produce no reply (zero length, short or
// suppressed tester present) are dropped at decode. Decode is combinational
// on the input channel and writes a small queue; the back end executes one
// queued request per cycle while the reply register is free or being taken,
// updating session and download state, and loads a reply register. Sustained
// rate is one item per cycle without output stall; an accepted request passes
// through the queue and then the reply register before its reply is visible.
// in_ready falls only when the queue is full. The security level mask is
// written through cfg_wr_en/cfg_wr_data and should only change while idle.
module uds_request_dispatcher #(
  parameter int unsigned QUEUE_DEPTH = uds_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_service_id,
  input  logic [7:0]  in_param_byte,
  input  logic [31:0] in_address_word,
  input  logic [31:0] in_size_word,
  input  logic [11:0] in_msg_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_outcome,
  output logic [7:0]  out_reply_id,
  output logic [7:0]  out_reply_param,
  output logic [2:0]  out_reply_length
);

  logic [1:0]        unlocked_levels_r;
  logic              keep;
  logic              push;
  logic              full;
  logic              pop;
  logic              head_valid;
  uds_pkg::q_entry_t front_entry;
  uds_pkg::q_entry_t head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unlocked_levels_r <= 2'b00;
    end else if (cfg_wr_en) begin
      unlocked_levels_r <= cfg_wr_data;
    end
  end

  assign in_ready = !full;
  assign push     = in_valid && in_ready && keep;

  uds_front u_front (
    .in_service_id   (in_service_id),
    .in_param_byte   (in_param_byte),
    .in_address_word (in_address_word),
    .in_size_word    (in_size_word),
    .in_msg_length   (in_msg_length),
    .keep            (keep),
    .entry           (front_entry)
  );

  uds_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (front_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  uds_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .unlocked_levels  (unlocked_levels_r),
    .head_valid       (head_valid),
    .head_entry       (head_entry),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_reply_id     (out_reply_id),
    .out_reply_param  (out_reply_param),
    .out_reply_length (out_reply_length)
  );

endmodule

>>> rtl/uds_front.sv
// Front end: decodes one request against the service table and builds a
// queue entry. Stateless; depends on uds_pkg.
module uds_front (
  input  logic [7:0]       in_service_id,
  input  logic [7:0]       in_param_byte,
  input  logic [31:0]      in_address_word,
  input  logic [31:0]      in_size_word,
  input  logic [11:0]      in_msg_length,
  output logic             keep,
  output uds_pkg::q_entry_t entry
);

  logic       len_ge2;
  logic [6:0] sub;

  assign len_ge2 = (in_msg_length >= 12'd2);
  assign sub     = in_param_byte[6:0];

  always_comb begin
    keep              = 1'b1;
    entry.op          = uds_pkg::OP_REJECT;
    entry.reject_code = uds_pkg::OC_NO_SERVICE;
    entry.sid         = in_service_id;
    entry.prm         = in_param_byte;
    entry.len_ok      = 1'b1;
    entry.take_addr   = 1'b0;
    entry.take_size   = 1'b0;
    entry.addr        = in_address_word;
    entry.size        = in_size_word;
    entry.xfer_bytes  = in_msg_length - 12'd2;
    case (in_service_id)
      uds_pkg::SID_SESSION: begin
        entry.prm = {1'b0, sub};
        if (!len_ge2) begin
          entry.reject_code = uds_pkg::OC_LENGTH;
        end else if (sub == 7'd1 || sub == 7'd2 || sub == 7'd3) begin
          entry.op = uds_pkg::OP_SESSION;
        end else begin
          entry.reject_code = uds_pkg::OC_NO_SUB;
        end
      end
      uds_pkg::SID_READ_ID: begin
        entry.reject_code = uds_pkg::OC_SEQUENCE;
      end
      uds_pkg::SID_SECURITY: begin
        entry.reject_code = len_ge2 ? uds_pkg::OC_NO_SERVICE : uds_pkg::OC_LENGTH;
      end
      uds_pkg::SID_DOWNLOAD: begin
        entry.op        = uds_pkg::OP_DOWNLOAD;
        entry.len_ok    = (in_msg_length >= 12'd5);
        entry.take_addr = (in_param_byte[3:0] == uds_pkg::FORMAT_FOUR_BYTES) &&
                          (in_msg_length >= 12'd6);
        entry.take_size = (in_param_byte[7:4] == uds_pkg::FORMAT_FOUR_BYTES) &&
                          (in_msg_length >= 12'd10);
      end
      uds_pkg::SID_TRANSFER: begin
        entry.op     = uds_pkg::OP_TRANSFER;
        entry.len_ok = (in_msg_length >= 12'd3);
      end
      uds_pkg::SID_EXIT: begin
        entry.op = uds_pkg::OP_EXIT;
      end
      uds_pkg::SID_TESTER: begin
        entry.op = uds_pkg::OP_TESTER;
        keep     = len_ge2 && (in_param_byte != uds_pkg::TESTER_SUPPRESS);
      end
      default: begin
        entry.reject_code = uds_pkg::OC_NO_SERVICE;
      end
    endcase
    // An empty request is dropped without effect.
    if (in_msg_length == 12'd0) begin
      keep = 1'b0;
    end
  end

endmodule

>>> rtl/uds_queue.sv
// Small register FIFO of classified requests between front and back end.
// Depends on uds_pkg for the entry type.
module uds_queue #(
  parameter int unsigned DEPTH = uds_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  uds_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output uds_pkg::q_entry_t head_entry
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  uds_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CW'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

>>> rtl/uds_back.sv
// Back end: executes classified requests against the session and download
// state and holds the reply in an output register. Depends on uds_pkg.
module uds_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        unlocked_levels,
  input  logic              head_valid,
  input  uds_pkg::q_entry_t head_entry,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_outcome,
  output logic [7:0]        out_reply_id,
  output logic [7:0]        out_reply_param,
  output logic [2:0]        out_reply_length
);

  uds_pkg::session_t session_r, session_nxt;
  uds_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]  expected_block_r, expected_block_nxt;
  logic [31:0] bytes_transferred_r, bytes_transferred_nxt;
  logic [31:0] download_address_r, download_address_nxt;
  logic [31:0] download_size_r, download_size_nxt;

  logic              out_valid_r;
  uds_pkg::outcome_t outcome_r, outcome_nxt;
  logic [7:0]        reply_id_r, reply_id_nxt;
  logic [7:0]        reply_param_r, reply_param_nxt;
  logic [2:0]        reply_length_r, reply_length_nxt;

  logic     gated_op;
  logic     gate_fail;
  logic     block_ok;
  uds_pkg::outcome_t gate_code;

  assign pop = head_valid && (!out_valid_r || out_ready);

  assign gated_op = (head_entry.op == uds_pkg::OP_DOWNLOAD) ||
                    (head_entry.op == uds_pkg::OP_TRANSFER) ||
                    (head_entry.op == uds_pkg::OP_EXIT);
  assign block_ok = (head_entry.prm == expected_block_r);

  // Session first, then security, then the request length, then the block number of a transfer.
  always_comb begin
    gate_fail = 1'b1;
    gate_code = uds_pkg::OC_CONDITIONS;
    if (session_r != uds_pkg::SESS_PROGRAMMING) begin
      gate_code = uds_pkg::OC_CONDITIONS;
    end else if (unlocked_levels == 2'b00) begin
      gate_code = uds_pkg::OC_SECURITY;
    end else if (!head_entry.len_ok) begin
      gate_code = uds_pkg::OC_LENGTH;
    end else if (head_entry.op == uds_pkg::OP_TRANSFER && !block_ok) begin
      gate_code = uds_pkg::OC_BLOCK;
    end else begin
      gate_fail = 1'b0;
    end
  end

  // Next state.
  always_comb begin
    session_nxt           = session_r;
    phase_nxt             = phase_r;
    expected_block_nxt    = expected_block_r;
    bytes_transferred_nxt = bytes_transferred_r;
    download_address_nxt  = download_address_r;
    download_size_nxt     = download_size_r;
    if (pop) begin
      case (head_entry.op)
        uds_pkg::OP_SESSION: begin
          case (head_entry.prm[1:0])
            2'd2:    session_nxt = uds_pkg::SESS_PROGRAMMING;
            2'd3:    session_nxt = uds_pkg::SESS_EXTENDED;
            default: session_nxt = uds_pkg::SESS_DEFAULT;
          endcase
        end
        uds_pkg::OP_DOWNLOAD: begin
          if (!gate_fail) begin
            if (head_entry.take_addr) begin
              download_address_nxt = head_entry.addr;
            end
            if (head_entry.take_size) begin
              download_size_nxt = head_entry.size;
            end
            phase_nxt             = uds_pkg::PHASE_REQUESTED;
            bytes_transferred_nxt = '0;
            expected_block_nxt    = 8'd1;
          end
        end
        uds_pkg::OP_TRANSFER: begin
          if (!gate_fail) begin
            phase_nxt             = uds_pkg::PHASE_TRANSFERRING;
            bytes_transferred_nxt = bytes_transferred_r + {20'd0, head_entry.xfer_bytes};
            expected_block_nxt    = expected_block_r + 8'd1;
          end
        end
        uds_pkg::OP_EXIT: begin
          if (!gate_fail) begin
            phase_nxt            = uds_pkg::PHASE_IDLE;
            download_address_nxt = '0;
            download_size_nxt    = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Reply for the item at the head of the queue.
  always_comb begin
    outcome_nxt      = uds_pkg::OC_OK;
    reply_id_nxt     = uds_pkg::RID_NEGATIVE;
    reply_param_nxt  = head_entry.sid;
    reply_length_nxt = uds_pkg::LEN_NEGATIVE;
    if (gated_op && gate_fail) begin
      outcome_nxt = gate_code;
    end else begin
      case (head_entry.op)
        uds_pkg::OP_SESSION: begin
          reply_id_nxt     = uds_pkg::RID_SESSION;
          reply_param_nxt  = head_entry.prm;
          reply_length_nxt = uds_pkg::LEN_SESSION;
        end
        uds_pkg::OP_DOWNLOAD: begin
          reply_id_nxt     = uds_pkg::RID_DOWNLOAD;
          reply_param_nxt  = uds_pkg::DOWNLOAD_FORMAT;
          reply_length_nxt = uds_pkg::LEN_DOWNLOAD;
        end
        uds_pkg::OP_TRANSFER: begin
          reply_id_nxt     = uds_pkg::RID_TRANSFER;
          reply_param_nxt  = head_entry.prm;
          reply_length_nxt = uds_pkg::LEN_TRANSFER;
        end
        uds_pkg::OP_EXIT: begin
          reply_id_nxt     = uds_pkg::RID_EXIT;
          reply_param_nxt  = 8'd0;
          reply_length_nxt = uds_pkg::LEN_SHORT;
        end
        uds_pkg::OP_TESTER: begin
          reply_id_nxt     = uds_pkg::RID_TESTER;
          reply_param_nxt  = 8'd0;
          reply_length_nxt = uds_pkg::LEN_SHORT;
        end
        default: begin
          outcome_nxt = head_entry.reject_code;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      session_r           <= uds_pkg::SESS_DEFAULT;
      phase_r             <= uds_pkg::PHASE_IDLE;
      expected_block_r    <= '0;
      bytes_transferred_r <= '0;
      download_address_r  <= '0;
      download_size_r     <= '0;
      out_valid_r         <= 1'b0;
    end else begin
      session_r           <= session_nxt;
      phase_r             <= phase_nxt;
      expected_block_r    <= expected_block_nxt;
      bytes_transferred_r <= bytes_transferred_nxt;
      download_address_r  <= download_address_nxt;
      download_size_r     <= download_size_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      outcome_r      <= outcome_nxt;
      reply_id_r     <= reply_id_nxt;
      reply_param_r  <= reply_param_nxt;
      reply_length_r <= reply_length_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = outcome_r;
  assign out_reply_id     = reply_id_r;
  assign out_reply_param  = reply_param_r;
  assign out_reply_length = reply_length_r;

  a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("reply register not loaded after a pop");

  a_negative_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_reply_id == uds_pkg::RID_NEGATIVE) |->
      (out_reply_length == uds_pkg::LEN_NEGATIVE && outcome_r != uds_pkg::OC_OK))
    else $error("negative reply with wrong frame");

  a_block_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_entry.op == uds_pkg::OP_TRANSFER && !gate_fail) |=>
      (expected_block_r == $past(expected_block_r) + 8'd1))
    else $error("block counter did not advance on accepted transfer");

endmodule

>>> test/tb_uds_request_dispatcher.sv
// Self-checking testbench for the diagnostic request dispatcher.
// Drives directed and random requests and predicts every reply in step.
// Depends on uds_pkg and uds_request_dispatcher.
module tb_uds_request_dispatcher;
  import uds_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 8;
  localparam int SETTLE_CYCLES  = 8;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int WRAP_TRANSFERS = 400;
  localparam int PRINT_LIMIT    = 100;

  localparam logic [6:0] SUB_DEFAULT     = 7'd1;
  localparam logic [6:0] SUB_PROGRAMMING = 7'd2;
  localparam logic [6:0] SUB_EXTENDED    = 7'd3;
  localparam logic [7:0] FORMAT_ADDR_SIZE = {FORMAT_FOUR_BYTES, FORMAT_FOUR_BYTES};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

  typedef struct packed {
    logic [7:0]  sid;
    logic [7:0]  prm;
    logic [31:0] addr;
    logic [31:0] size;
    logic [11:0] len;
  } request_t;

  typedef struct packed {
    outcome_t   oc;
    logic [7:0] id;
    logic [7:0] prm;
    logic [2:0] len;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = 2'b00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_service_id = 8'h00;
  logic [7:0]  in_param_byte = 8'h00;
  logic [31:0] in_address_word = 32'h0;
  logic [31:0] in_size_word = 32'h0;
  logic [11:0] in_msg_length = 12'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_outcome;
  logic [7:0]  out_reply_id;
  logic [7:0]  out_reply_param;
  logic [2:0]  out_reply_length;

  uds_request_dispatcher dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_service_id    (in_service_id),
    .in_param_byte    (in_param_byte),
    .in_address_word  (in_address_word),
    .in_size_word     (in_size_word),
    .in_msg_length    (in_msg_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_outcome      (out_outcome),
    .out_reply_id     (out_reply_id),
    .out_reply_param  (out_reply_param),
    .out_reply_length (out_reply_length)
  );

  always #(CLK_HALF) clk = ~clk;

  // Predicted dispatcher state, advanced at each accepted item.
  logic [1:0]  unlocked = 2'b00;
  session_t    session = SESS_DEFAULT;
  logic [7:0]  next_block = 8'd0;
  logic [31:0] byte_count = 32'd0;
  logic [31:0] dl_addr = 32'd0;
  logic [31:0] dl_size = 32'd0;
  phase_t      dl_phase = PHASE_IDLE;

  request_t    requests_waiting[$];
  reply_t      replies_due[$];
  request_t    presented;
  bit          presenting = 1'b0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          request_count = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;

  function automatic void predict_reply(input request_t r);
    reply_t     rep;
    logic [6:0] sub;
    rep = '{OC_NO_SERVICE, RID_NEGATIVE, r.sid, LEN_NEGATIVE};
    sub = r.prm[6:0];
    if (r.len == 12'd0) return;
    case (r.sid)
      SID_SESSION: begin
        if (r.len < 12'd2) rep.oc = OC_LENGTH;
        else if (sub == SUB_DEFAULT || sub == SUB_PROGRAMMING || sub == SUB_EXTENDED) begin
          case (sub)
            SUB_DEFAULT:     session = SESS_DEFAULT;
            SUB_PROGRAMMING: session = SESS_PROGRAMMING;
            default:         session = SESS_EXTENDED;
          endcase
          rep = '{OC_OK, RID_SESSION, {1'b0, sub}, LEN_SESSION};
        end else rep.oc = OC_NO_SUB;
      end
      SID_READ_ID: rep.oc = OC_SEQUENCE;
      SID_SECURITY: rep.oc = (r.len < 12'd2) ? OC_LENGTH : OC_NO_SERVICE;
      SID_DOWNLOAD, SID_TRANSFER, SID_EXIT: begin
        if (session != SESS_PROGRAMMING) rep.oc = OC_CONDITIONS;
        else if (unlocked == 2'b00) rep.oc = OC_SECURITY;
        else if (r.sid == SID_DOWNLOAD) begin
          if (r.len < 12'd5) rep.oc = OC_LENGTH;
          else begin
            // Address and size are only taken when the message carries them.
            if (r.prm[3:0] == FORMAT_FOUR_BYTES && r.len >= 12'd6) dl_addr = r.addr;
            if (r.prm[7:4] == FORMAT_FOUR_BYTES && r.len >= 12'd10) dl_size = r.size;
            dl_phase = PHASE_REQUESTED;
            byte_count = 32'd0;
            next_block = 8'd1;
            rep = '{OC_OK, RID_DOWNLOAD, DOWNLOAD_FORMAT, LEN_DOWNLOAD};
          end
        end else if (r.sid == SID_TRANSFER) begin
          if (r.len < 12'd3) rep.oc = OC_LENGTH;
          else if (r.prm != next_block) rep.oc = OC_BLOCK;
          else begin
            dl_phase = PHASE_TRANSFERRING;
            byte_count = byte_count + 32'(r.len - 12'd2);
            next_block = next_block + 8'd1;
            rep = '{OC_OK, RID_TRANSFER, r.prm, LEN_TRANSFER};
          end
        end else begin
          dl_phase = PHASE_IDLE;
          dl_addr = 32'd0;
          dl_size = 32'd0;
          rep = '{OC_OK, RID_EXIT, 8'h00, LEN_SHORT};
        end
      end
      SID_TESTER: begin
        if (r.len < 12'd2 || r.prm == TESTER_SUPPRESS) return;
        rep = '{OC_OK, RID_TESTER, 8'h00, LEN_SHORT};
      end
      default: ;
    endcase
    replies_due.push_back(rep);
  endfunction

  function automatic void add_request(input logic [7:0] sid, input logic [7:0] prm,
                                      input logic [31:0] addr, input logic [31:0] size,
                                      input logic [11:0] len);
    requests_waiting.push_back('{sid, prm, addr, size, len});
    if (len != 12'd0) request_count++;
  endfunction

  // Programming session, download request, a run of transfers and an exit.
  function automatic void add_download_sequence(input int transfers);
    logic [7:0]  blk;
    logic [7:0]  fmt;
    logic [7:0]  prm;
    logic [11:0] len;
    int          roll;
    blk = 8'd1;
    add_request(SID_SESSION, {1'($urandom_range(1)), SUB_PROGRAMMING}, $urandom, $urandom,
                12'($urandom_range(2, 8)));
    fmt = ($urandom_range(99) < 80) ? FORMAT_ADDR_SIZE : 8'($urandom);
    len = ($urandom_range(99) < 70) ? 12'd10 : 12'($urandom_range(1, 12));
    add_request(SID_DOWNLOAD, fmt, $urandom, $urandom, len);
    for (int i = 0; i < transfers; i++) begin
      roll = $urandom_range(99);
      if (roll < 6)
        add_request(SID_TESTER, ($urandom_range(1) == 0) ? TESTER_SUPPRESS : 8'($urandom),
                    $urandom, $urandom, 12'($urandom_range(0, 3)));
      prm = (roll < 12) ? 8'($urandom) : blk;
      if (roll >= 95) len = 12'($urandom_range(0, 2));
      else if (roll >= 85) len = 12'($urandom_range(3, 4095));
      else len = 12'($urandom_range(3, 64));
      add_request(SID_TRANSFER, prm, $urandom, $urandom, len);
      if (prm == blk && len >= 12'd3) blk = blk + 8'd1;
    end
    add_request(SID_EXIT, 8'($urandom), $urandom, $urandom, 12'($urandom_range(1, 4)));
  endfunction

  function automatic void add_noise_request();
    logic [7:0]  sid;
    logic [7:0]  prm;
    logic [11:0] len;
    case ($urandom_range(9))
      0:       sid = SID_SESSION;
      1:       sid = SID_READ_ID;
      2:       sid = SID_SECURITY;
      3:       sid = SID_DOWNLOAD;
      4:       sid = SID_TRANSFER;
      5:       sid = SID_EXIT;
      6:       sid = SID_TESTER;
      default: sid = 8'($urandom);
    endcase
    prm = 8'($urandom);
    if (sid == SID_SESSION && $urandom_range(1) == 0)
      prm = {1'($urandom_range(1)), 7'($urandom_range(1, 3))};
    case ($urandom_range(3))
      0:       len = 12'($urandom_range(0, 3));
      1:       len = 12'($urandom_range(4, 12));
      2:       len = 12'($urandom);
      default: len = 12'($urandom_range(1, 64));
    endcase
    add_request(sid, prm, $urandom, $urandom, len);
  endfunction

  task automatic set_idling(input idling_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 61; stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 61; end
      default:       begin send_idle_pct = 22; stall_pct = 22; end
    endcase
  endtask

  // Holds the sender back until every predicted reply has come out.
  task automatic wait_idle();
    while (requests_waiting.size() != 0 || presenting || replies_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_levels(input logic [1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unlocked = value;
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_reply(presented);
        presenting = 1'b0;
      end
      if (!presenting && requests_waiting.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        presented = requests_waiting.pop_front();
        presenting = 1'b1;
        in_service_id <= presented.sid;
        in_param_byte <= presented.prm;
        in_address_word <= presented.addr;
        in_size_word <= presented.size;
        in_msg_length <= presented.len;
      end
      in_valid <= presenting;
    end
  end

  always @(posedge clk) begin : monitor
    reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply arrived with no request awaiting one");
        end else begin
          want = replies_due.pop_front();
          if (out_outcome !== want.oc)
            report_mismatch($sformatf("outcome %0d, predicted %0d", out_outcome, want.oc));
          if (out_reply_id !== want.id)
            report_mismatch($sformatf("reply id %h, predicted %h", out_reply_id, want.id));
          if (out_reply_param !== want.prm)
            report_mismatch($sformatf("reply param %h, predicted %h", out_reply_param,
                                      want.prm));
          if (out_reply_length !== want.len)
            report_mismatch($sformatf("reply length %0d, predicted %0d", out_reply_length,
                                      want.len));
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests with every security level still locked.
    set_idling(IDLE_NONE);
    add_request(SID_TESTER, 8'h00, 32'h0, 32'h0, 12'd0);
    add_request(SID_SESSION, 8'h02, 32'h0, 32'h0, 12'd1);
    add_request(SID_SESSION, 8'h81, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    add_request(SID_SESSION, 8'h00, 32'h0, 32'h0, 12'd2);
    add_request(SID_SESSION, 8'hFF, 32'h0, 32'h0, 12'd2);
    add_request(SID_READ_ID, 8'hFF, 32'h0, 32'h0, 12'd1);
    add_request(SID_SECURITY, 8'h01, 32'h0, 32'h0, 12'd1);
    add_request(SID_SECURITY, 8'h01, 32'h0, 32'h0, 12'd2);
    add_request(SID_DOWNLOAD, FORMAT_ADDR_SIZE, 32'h1, 32'h2, 12'd10);
    add_request(SID_SESSION, 8'h03, 32'h0, 32'h0, 12'd2);
    add_request(SID_TRANSFER, 8'h01, 32'h0, 32'h0, 12'd4);
    add_request(SID_SESSION, 8'h02, 32'h0, 32'h0, 12'd2);
    add_request(SID_EXIT, 8'h00, 32'h0, 32'h0, 12'd1);
    add_request(SID_TESTER, TESTER_SUPPRESS, 32'h0, 32'h0, 12'd2);
    add_request(SID_TESTER, 8'h00, 32'h0, 32'h0, 12'd1);
    add_request(SID_TESTER, 8'h7F, 32'h0, 32'h0, 12'd2);
    add_request(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd1);
    wait_idle();

    // Directed download with both levels unlocked.
    write_levels(2'b11);
    set_idling(IDLE_BOTH);
    add_request(SID_DOWNLOAD, FORMAT_ADDR_SIZE, 32'h0, 32'h0, 12'd4);
    add_request(SID_DOWNLOAD, FORMAT_ADDR_SIZE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'd10);
    add_request(SID_DOWNLOAD, FORMAT_ADDR_SIZE, 32'h0, 32'h0, 12'd9);
    add_request(SID_TRANSFER, 8'h01, 32'h0, 32'h0, 12'd2);
    add_request(SID_TRANSFER, 8'h02, 32'h0, 32'h0, 12'd3);
    add_request(SID_TRANSFER, 8'h01, 32'h0, 32'h0, 12'hFFF);
    add_request(SID_TRANSFER, 8'h02, 32'h0, 32'h0, 12'd3);
    add_request(SID_EXIT, 8'hFF, 32'h0, 32'h0, 12'd1);
    add_request(SID_SESSION, 8'h01, 32'h0, 32'h0, 12'd2);
    wait_idle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_levels(2'(p + 1));
      set_idling(idling_t'(p % 4));
      request_count = 0;
      while (request_count < PHASE_ITEMS) begin
        if ($urandom_range(99) < 70) add_download_sequence($urandom_range(1, 10));
        else add_noise_request();
      end
      wait_idle();
    end

    // One long transfer run so the block counter wraps past its top value.
    write_levels(2'b01);
    set_idling(IDLE_RECEIVER);
    add_download_sequence(WRAP_TRANSFERS);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
